// ===== sv/step_pulse_ramp_controller_defines.svh =====
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef STEP_PULSE_RAMP_CONTROLLER_DEFINES_SVH
`define STEP_PULSE_RAMP_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SPRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sprc_pkg.sv =====
package sprc_pkg;

  localparam int unsigned FREQ_BITS_DEF = 20;
  localparam int unsigned TIME_BITS_DEF = 32;

  // internal frequency width, bounded by the freq_max register
  localparam int unsigned FW      = 20;
  localparam int unsigned MSW     = 16;
  localparam int unsigned CAP_W   = 21;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 20;
  localparam int unsigned DIV_NW  = FW + MSW;
  localparam int unsigned DIV_DW  = MSW;

  // span / 60 as a multiply by ceil(2^26 / 60), exact for any 20-bit span
  localparam int unsigned      RCP_W      = 21;
  localparam int unsigned      RCP_SH     = 26;
  localparam logic [RCP_W-1:0] CRUISE_RCP = RCP_W'(1118482);

  localparam logic [FW:0]    CRUISE_MIN_STEP = (FW+1)'(50);
  localparam logic [FW-1:0]  PULSE_LIMIT     = FW'(1000000);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_UP     = 3'd1,
    MODE_CRUISE = 3'd2,
    MODE_DOWN   = 3'd3,
    MODE_REV    = 3'd4
  } motion_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_ESTOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_NONE    = 2'd0,
    DIR_EAST    = 2'd1,
    DIR_TO_WEST = 2'd2,
    DIR_BAD     = 2'd3
  } dir_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_FREQ_MIN   = 3'd0,
    REG_FREQ_MAX   = 3'd1,
    REG_RAMP_UP    = 3'd2,
    REG_RAMP_DOWN  = 3'd3,
    REG_STEP_PER   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_APPLY
  } ctrl_state_e;

  typedef struct packed {
    logic latch_in;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== sv/step_pulse_ramp_controller.sv =====
// Pulse frequency ramp controller. Each item on the slave stream is a tick, set target,
// stop or emergency stop (tuser); each gives one result on the master stream with the
// latched pulse frequency, direction pin, servo-on line and motion mode. An item is latched,
// decoded in the execute state and committed in the apply state; a tick that runs a ramp up,
// ramp down or reversing step first waits in the divide state on the one-bit-per-cycle divider
// for the ramp interpolation, while the cruise decrement uses a reciprocal multiply. One item is
// worked on at a time; the next is taken while the previous result waits, and is committed once
// that result is taken.
// Configuration writes must be made while no item is in flight.
`include "step_pulse_ramp_controller_defines.svh"

module step_pulse_ramp_controller
  import sprc_pkg::*;
#(
  parameter int unsigned FREQ_BITS = FREQ_BITS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  localparam int unsigned IN_W  = TIME_BITS + FREQ_BITS + 2 + CAP_W,
  localparam int unsigned IN_DW = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = FREQ_BITS + 5,
  localparam int unsigned OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // now_ms, target_freq, direction, freq_cap, zero fill
  input  logic [IN_DW-1:0]  s_axis_tdata,
  // cmd
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pulse_freq, dir_level, servo_enable, motion_mode, zero fill
  output logic [OUT_DW-1:0] m_axis_tdata
);

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [FREQ_BITS-1:0] pulse_freq;
  logic                 dir_level, servo_enable;
  logic [2:0]           motion_mode;

  sprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sprc_dp #(
    .FREQ_BITS (FREQ_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_cmd_i       (s_axis_tuser),
    .in_now_i       (s_axis_tdata[TIME_BITS-1:0]),
    .in_target_i    (s_axis_tdata[TIME_BITS +: FREQ_BITS]),
    .in_dir_i       (s_axis_tdata[TIME_BITS+FREQ_BITS +: 2]),
    .in_cap_i       (s_axis_tdata[TIME_BITS+FREQ_BITS+2 +: CAP_W]),
    .pulse_freq_o   (pulse_freq),
    .dir_level_o    (dir_level),
    .servo_enable_o (servo_enable),
    .motion_mode_o  (motion_mode)
  );

  assign m_axis_tdata = OUT_DW'({motion_mode, servo_enable, dir_level, pulse_freq});

  `SPRC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "item taken while previous still in work")
  `SPRC_ASSERT_IMP(a_pulse_needs_servo, pulse_freq != '0, servo_enable,
    "pulse driven with servo off")
  `SPRC_ASSERT_IMP(a_idle_silent, motion_mode == MODE_IDLE, pulse_freq == '0,
    "pulse driven while idle")

endmodule

// ===== sv/sprc_div.sv =====
module sprc_div
  import sprc_pkg::*;
#(
  parameter int unsigned NUM_W = DIV_NW,
  parameter int unsigned DEN_W = DIV_DW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             done_o
);

  localparam int unsigned CW = $clog2(NUM_W);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // one quotient bit a cycle, restoring
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== sv/sprc_dp.sv =====
module sprc_dp
  import sprc_pkg::*;
#(
  parameter int unsigned FREQ_BITS = FREQ_BITS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_addr_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  input  logic [1:0]           in_cmd_i,
  input  logic [TIME_BITS-1:0] in_now_i,
  input  logic [FREQ_BITS-1:0] in_target_i,
  input  logic [1:0]           in_dir_i,
  input  logic [CAP_W-1:0]     in_cap_i,
  output logic [FREQ_BITS-1:0] pulse_freq_o,
  output logic                 dir_level_o,
  output logic                 servo_enable_o,
  output logic [2:0]           motion_mode_o
);

  localparam int unsigned WW = (FREQ_BITS > FW) ? FREQ_BITS : FW;
  localparam int unsigned PW = FW + RCP_W;

  // configuration
  logic [FW-1:0]  fmin_q, fmax_q;
  logic [MSW-1:0] ru_q, rd_q, sp_q;

  // latched item
  cmd_e                 icmd_q;
  logic [TIME_BITS-1:0] now_q;
  logic [FREQ_BITS-1:0] tf_q;
  dir_e                 idir_q;
  logic [CAP_W-1:0]     cap_q;

  // controller state
  motion_e              mode_q, mode_d;
  logic [FW-1:0]        pres_q, pres_d;
  dir_e                 pdir_q, pdir_d;
  logic [FW-1:0]        goal_q, goal_d;
  dir_e                 qdir_q, qdir_d;
  logic [FW-1:0]        qfreq_q, qfreq_d;
  logic [TIME_BITS-1:0] rst_q, rst_d;
  logic [FW-1:0]        rsf_q, rsf_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic                 servo_q, servo_d;
  logic [FW-1:0]        ofreq_q, ofreq_d;
  logic                 odir_q, odir_d;

  logic [TIME_BITS-1:0] elapsed, since_last;
  logic                 step_due, up_done, dn_done;
  logic [FW-1:0]        tgt, up_mag, fset;
  logic                 up_neg, stop_req;
  logic [DIV_NW-1:0]    div_num, div_quo;
  logic [DIV_DW-1:0]    div_den;
  logic                 div_need, div_done;
  logic [FW:0]          q21, stp;
  logic signed [FW+1:0] v22;
  logic [FW-1:0]        span;
  logic [PW-1:0]        span_prod;
  logic [PW-RCP_SH-1:0] cruise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmin_q <= FW'(100);
      fmax_q <= FW'(100000);
      ru_q   <= MSW'(2000);
      rd_q   <= MSW'(2000);
      sp_q   <= MSW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_FREQ_MIN:  fmin_q <= cfg_wdata_i;
        REG_FREQ_MAX:  fmax_q <= cfg_wdata_i;
        REG_RAMP_UP:   ru_q   <= cfg_wdata_i[MSW-1:0];
        REG_RAMP_DOWN: rd_q   <= cfg_wdata_i[MSW-1:0];
        REG_STEP_PER:  sp_q   <= cfg_wdata_i[MSW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      icmd_q <= cmd_e'(in_cmd_i);
      now_q  <= in_now_i;
      tf_q   <= in_target_i;
      idir_q <= (dir_e'(in_dir_i) == DIR_BAD) ? DIR_NONE : dir_e'(in_dir_i);
      cap_q  <= in_cap_i;
    end
  end

  // shared decode, stable from EXEC to APPLY
  always_comb begin
    elapsed    = now_q - rst_q;
    since_last = now_q - last_q;
    step_due   = since_last >= TIME_BITS'(sp_q);
    up_done    = elapsed >= TIME_BITS'(ru_q);
    dn_done    = elapsed >= TIME_BITS'(rd_q);
    tgt = goal_q;
    if (!cap_q[CAP_W-1] && ({1'b0, tgt} > cap_q)) tgt = cap_q[FW-1:0];
    if ((tgt != '0) && (tgt < fmin_q)) tgt = fmin_q;
    if (tgt > fmax_q) tgt = fmax_q;
    up_neg = tgt < rsf_q;
    up_mag = up_neg ? (rsf_q - tgt) : (tgt - rsf_q);
    div_need = 1'b0;
    div_num  = '0;
    div_den  = rd_q;
    if ((icmd_q == CMD_TICK) && step_due) begin
      unique case (mode_q)
        MODE_UP: begin
          div_need = !up_done;
          div_num  = DIV_NW'(up_mag) * DIV_NW'(elapsed[MSW-1:0]);
          div_den  = ru_q;
        end
        MODE_DOWN: begin
          div_need = !dn_done;
          div_num  = DIV_NW'(rsf_q) * DIV_NW'(elapsed[MSW-1:0]);
        end
        MODE_REV: begin
          div_need = !dn_done && (pres_q != '0);
          div_num  = DIV_NW'(rsf_q) * DIV_NW'(elapsed[MSW-1:0]);
        end
        default: ;
      endcase
    end
  end

  sprc_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DIV_DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  assign sts_o.div_need = div_need;
  assign sts_o.div_done = div_done;

  always_comb begin
    q21       = div_quo[FW:0];
    span      = (fmax_q > fmin_q) ? (fmax_q - fmin_q) : '0;
    span_prod = PW'(span) * PW'(CRUISE_RCP);
    cruise_q  = span_prod[PW-1:RCP_SH];
    stp       = ((FW+1)'(cruise_q) < CRUISE_MIN_STEP) ? CRUISE_MIN_STEP
                                                      : (FW+1)'(cruise_q);
    v22      = '0;
    fset     = (WW'(tf_q) > WW'(fmax_q)) ? fmax_q : FW'(tf_q);
    stop_req = (icmd_q == CMD_STOP) ||
               ((icmd_q == CMD_SET) && ((tf_q == '0) || (idir_q == DIR_NONE)));
    mode_d  = mode_q;
    pres_d  = pres_q;
    pdir_d  = pdir_q;
    goal_d  = goal_q;
    qdir_d  = qdir_q;
    qfreq_d = qfreq_q;
    rst_d   = rst_q;
    rsf_d   = rsf_q;
    last_d  = last_q;
    servo_d = servo_q;
    ofreq_d = ofreq_q;
    odir_d  = odir_q;
    if (cmd_i.commit) begin
      if (icmd_q == CMD_ESTOP) begin
        ofreq_d = '0;
        servo_d = 1'b0;
        pres_d  = '0;
        pdir_d  = DIR_NONE;
        mode_d  = MODE_IDLE;
        qdir_d  = DIR_NONE;
      end else if (stop_req) begin
        if ((mode_q != MODE_IDLE) && (mode_q != MODE_DOWN)) begin
          if (pres_q == '0) begin
            mode_d = MODE_IDLE;
            pdir_d = DIR_NONE;
          end else begin
            mode_d = MODE_DOWN;
            rst_d  = now_q;
            rsf_d  = pres_q;
            qdir_d = DIR_NONE;
          end
        end
      end else if (icmd_q == CMD_SET) begin
        if ((mode_q == MODE_REV) && (qdir_q == idir_q)) begin
          qfreq_d = fset;
        end else if ((pdir_q != DIR_NONE) && (pdir_q != idir_q)) begin
          qdir_d  = idir_q;
          qfreq_d = fset;
          mode_d  = MODE_REV;
          rst_d   = now_q;
          rsf_d   = pres_q;
        end else begin
          goal_d = fset;
          pdir_d = idir_q;
          if ((mode_q == MODE_IDLE) || (mode_q == MODE_DOWN)) begin
            mode_d = MODE_UP;
            rst_d  = now_q;
            rsf_d  = pres_q;
          end
        end
      end else if (step_due) begin
        last_d = now_q;
        unique case (mode_q)
          MODE_UP: begin
            if (up_done) begin
              pres_d = tgt;
              mode_d = MODE_CRUISE;
            end else begin
              v22 = up_neg ? ($signed({2'b00, rsf_q}) - $signed({1'b0, q21}))
                           : ($signed({2'b00, rsf_q}) + $signed({1'b0, q21}));
              if (v22 < $signed({2'b00, fmin_q})) v22 = $signed({2'b00, fmin_q});
              if (v22 > $signed({2'b00, tgt})) v22 = $signed({2'b00, tgt});
              pres_d = v22[FW-1:0];
            end
          end
          MODE_CRUISE: begin
            if (pres_q < tgt) begin
              mode_d = MODE_UP;
              rst_d  = now_q;
              rsf_d  = pres_q;
            end else if (pres_q > tgt) begin
              v22 = $signed({2'b00, pres_q}) - $signed({1'b0, stp});
              if (v22 < $signed({2'b00, tgt})) v22 = $signed({2'b00, tgt});
              pres_d = v22[FW-1:0];
            end
          end
          MODE_DOWN: begin
            if (dn_done) begin
              pres_d = '0;
              pdir_d = DIR_NONE;
              mode_d = MODE_IDLE;
            end else begin
              pres_d = rsf_q - q21[FW-1:0];
            end
          end
          MODE_REV: begin
            if (dn_done || (pres_q == '0)) begin
              pres_d = '0;
              pdir_d = qdir_q;
              goal_d = qfreq_q;
              mode_d = MODE_UP;
              rst_d  = now_q;
              rsf_d  = '0;
              qdir_d = DIR_NONE;
            end else begin
              pres_d = rsf_q - q21[FW-1:0];
            end
          end
          default: begin
            mode_d = MODE_IDLE;
            pres_d = '0;
          end
        endcase
        // drive the lines from the new state
        if ((pres_d == '0) || (pdir_d == DIR_NONE)) begin
          ofreq_d = '0;
        end else begin
          servo_d = 1'b1;
          odir_d  = pdir_d == DIR_TO_WEST;
          ofreq_d = (pres_d > PULSE_LIMIT) ? PULSE_LIMIT : pres_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pres_q  <= '0;
      pdir_q  <= DIR_NONE;
      goal_q  <= '0;
      qdir_q  <= DIR_NONE;
      qfreq_q <= '0;
      rst_q   <= '0;
      rsf_q   <= '0;
      last_q  <= '0;
      servo_q <= 1'b0;
      ofreq_q <= '0;
      odir_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pres_q  <= pres_d;
      pdir_q  <= pdir_d;
      goal_q  <= goal_d;
      qdir_q  <= qdir_d;
      qfreq_q <= qfreq_d;
      rst_q   <= rst_d;
      rsf_q   <= rsf_d;
      last_q  <= last_d;
      servo_q <= servo_d;
      ofreq_q <= ofreq_d;
      odir_q  <= odir_d;
    end
  end

  assign pulse_freq_o   = FREQ_BITS'(ofreq_q);
  assign dir_level_o    = odir_q;
  assign servo_enable_o = servo_q;
  assign motion_mode_o  = mode_q;

endmodule

// ===== sv/sprc_ctrl.sv =====
module sprc_ctrl
  import sprc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        ovalid_q, ovalid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    out_free   = !ovalid_q || out_ready_i;
    state_d    = state_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.div_need) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        // the result is the state itself, so wait until the last one is taken
        if (out_free) begin
          cmd_o.commit = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;

endmodule
